// ----- src/pvpp_pkg.sv -----
// Package: shared constants, types and CORDIC tables for the phase propagation core.
`timescale 1ns / 1ps
package pvpp_pkg;

    localparam int FftSize      = 1024;
    localparam int FftLog2      = $clog2(FftSize);
    localparam int StateDepth   = 1024;
    localparam int StateAw      = $clog2(StateDepth);
    localparam int CordicSteps  = 14;
    localparam int InvGainQ16   = 39797;
    localparam int ExtraBits    = 8;
    localparam int DataW        = 24;
    localparam int CordW        = 36;
    localparam int PhaseW       = 16;
    localparam int CfgIdxW      = 2;
    localparam int CfgDataW     = 16;

    localparam logic [CfgIdxW-1:0] CfgAnalysisHop  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgSynthesisHop = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgHopRatio     = 2'd2;

    typedef logic signed [CordW-1:0] cord_t;
    typedef logic        [PhaseW-1:0] phase_t;

    typedef struct packed {
        cord_t  x;
        cord_t  y;
        logic signed [17:0] z;
    } cord_state_t;

    function automatic logic signed [17:0] atan_bam(input int i);
        logic signed [17:0] r;
        begin
            case (i)
                0:       r = 18'sd8192;
                1:       r = 18'sd4836;
                2:       r = 18'sd2555;
                3:       r = 18'sd1297;
                4:       r = 18'sd651;
                5:       r = 18'sd326;
                6:       r = 18'sd163;
                7:       r = 18'sd81;
                8:       r = 18'sd41;
                9:       r = 18'sd20;
                10:      r = 18'sd10;
                11:      r = 18'sd5;
                12:      r = 18'sd3;
                13:      r = 18'sd1;
                default: r = 18'sd0;
            endcase
            return r;
        end
    endfunction

    // One micro-rotation; vec selects vectoring (drive y) or rotation (drive z).
    function automatic cord_state_t cordic_step(input cord_state_t s, input int i,
                                                input logic vec);
        cord_state_t r;
        cord_t dx;
        cord_t dy;
        logic  pos;
        begin
            dx  = s.y >>> i;
            dy  = s.x >>> i;
            pos = vec ? (s.y >= 0) : (s.z < 0);
            r   = s;
            if (pos == vec)
            begin
                r.x = s.x + (vec ? dx : -dx);
                r.y = s.y - (vec ? dy : -dy);
                r.z = vec ? s.z + atan_bam(i) : s.z - atan_bam(i);
            end
            else
            begin
                r.x = s.x - (vec ? dx : -dx);
                r.y = s.y + (vec ? dy : -dy);
                r.z = vec ? s.z - atan_bam(i) : s.z + atan_bam(i);
            end
            return r;
        end
    endfunction

    // Bin advance: ((hop*bin) mod N) * 65536 / N rounded half up, mod 65536.
    function automatic phase_t bin_advance(input logic [13:0] hop,
                                           input logic [StateAw-1:0] bin);
        logic [23:0]        prod;
        logic [FftLog2-1:0] r;
        logic [FftLog2+16:0] t;
        begin
            prod = 24'(hop) * 24'(bin);
            r    = prod[FftLog2-1:0];
            t    = ((FftLog2+17)'(r) << 16) + (FftLog2+17)'(FftSize / 2);
            return t[FftLog2+15:FftLog2];
        end
    endfunction

endpackage

// ----- src/pvpp_if.sv -----
// Interfaces: input and output valid/ready channels.
`timescale 1ns / 1ps
interface pvpp_in_if;
    logic                    valid;
    logic                    ready;
    logic                    first_frame;
    logic [9:0]              bin_index;
    logic signed [23:0]      real_part;
    logic signed [23:0]      imag_part;
    modport source (output valid, first_frame, bin_index, real_part, imag_part, input ready);
    modport sink   (input valid, first_frame, bin_index, real_part, imag_part, output ready);
endinterface

interface pvpp_out_if;
    logic                    valid;
    logic                    ready;
    logic signed [23:0]      out_real;
    logic signed [23:0]      out_imag;
    logic [9:0]              out_bin;
    modport source (output valid, out_real, out_imag, out_bin, input ready);
    modport sink   (input valid, out_real, out_imag, out_bin, output ready);
endinterface

// ----- src/pvpp_cordic.sv -----
// Pipelined CORDIC, one micro-rotation per stage, with shared advance enable.
`timescale 1ns / 1ps
module pvpp_cordic (
    input  logic                  clk,
    input  logic                  en,
    input  logic                  vec,
    input  pvpp_pkg::cord_state_t in_s,
    output pvpp_pkg::cord_state_t out_s
);
    pvpp_pkg::cord_state_t st_reg [pvpp_pkg::CordicSteps];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= pvpp_pkg::cordic_step(in_s, 0, vec);
            for (int i = 1; i < pvpp_pkg::CordicSteps; i++)
            begin
                st_reg[i] <= pvpp_pkg::cordic_step(st_reg[i-1], i, vec);
            end
        end
    end

    assign out_s = st_reg[pvpp_pkg::CordicSteps-1];
endmodule

// ----- src/phase_vocoder_phase_propagation_core.sv -----
// Top level: phase propagation core of a phase vocoder.
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | first_frame, bin_index, real_part, imag_part
//  out_ch   | out | valid/ready  | out_real, out_imag, out_bin
//  cfg      | in  | cfg_we       | cfg_index, cfg_data
// One bin per cycle sustained while out_ch is not stalled and no clearing pass runs;
// the two 14-stage CORDICs set the depth.
// Pipeline advances as one whole while the output stage is free or being taken.
// State memories reset by a clearing pass over every bin address, no bin taken meanwhile.
// Phase state of a bin still in the stages ahead is forwarded, so bins may repeat freely.
`timescale 1ns / 1ps
module phase_vocoder_phase_propagation_core (
    input  logic              clk,
    input  logic              rst_n,
    pvpp_in_if.sink           in_ch,
    pvpp_out_if.source        out_ch,
    input  logic              cfg_we,
    input  logic [pvpp_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [pvpp_pkg::CfgDataW-1:0] cfg_data
);
    localparam int Aw = pvpp_pkg::StateAw;
    localparam int Cw = pvpp_pkg::CordW;
    localparam int Ns = pvpp_pkg::CordicSteps;
    // Stage numbers of gain/state read, deviation and scale/output phase.
    localparam int StA = Ns + 1;
    localparam int StB = Ns + 2;
    localparam int StC = Ns + 3;

    logic [10:0] ahop_reg;
    logic [13:0] shop_reg;
    logic [15:0] ratio_reg;
    logic [Aw:0] clr_reg;
    logic        clearing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ahop_reg  <= 11'd256;
            shop_reg  <= 14'd256;
            ratio_reg <= 16'd4096;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pvpp_pkg::CfgAnalysisHop:  ahop_reg  <= cfg_data[10:0];
                pvpp_pkg::CfgSynthesisHop: shop_reg  <= cfg_data[13:0];
                pvpp_pkg::CfgHopRatio:     ratio_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clearing)
            clr_reg <= clr_reg + 1'b1;
    end
    assign clearing = !clr_reg[Aw];

    // Pipeline: stage 0 input reg, vectoring CORDIC (14), gain, deviation, scale,
    // rotation pre-fold, rotation CORDIC (14), gain; the output register follows.
    localparam int Depth = 1 + Ns + 1 + 1 + 1 + 1 + Ns + 1;
    logic [Depth-1:0] v_reg;
    logic adv;
    logic out_valid_reg;
    assign adv = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv && !clearing;
    wire take = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[Depth-2:0], take};
    end

    // Side-band: bin and first flag delayed alongside the CORDIC.
    localparam int Lv = 1 + Ns;
    logic [Aw:0] side_reg [Lv];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= {in_ch.first_frame, in_ch.bin_index};
            for (int i = 1; i < Lv; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // Stage 0: pre-rotate into the right half plane.
    pvpp_pkg::cord_state_t v0_reg, v_out;
    logic zero_reg [Lv];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v0_reg.x <= in_ch.real_part[23] ? -(Cw'(in_ch.real_part) <<< 8)
                                            : (Cw'(in_ch.real_part) <<< 8);
            v0_reg.y <= in_ch.real_part[23] ? -(Cw'(in_ch.imag_part) <<< 8)
                                            : (Cw'(in_ch.imag_part) <<< 8);
            v0_reg.z <= in_ch.real_part[23] ? 18'sh08000 : 18'sd0;
            zero_reg[0] <= (in_ch.real_part == 0) && (in_ch.imag_part == 0);
            for (int i = 1; i < Lv; i++)
                zero_reg[i] <= zero_reg[i-1];
        end
    end

    pvpp_cordic u_vec (.clk(clk), .en(adv), .vec(1'b1), .in_s(v0_reg), .out_s(v_out));

    logic signed [Cw+17:0] mprod;
    pvpp_pkg::cord_t  mag_a_reg;
    pvpp_pkg::phase_t ph_a_reg;
    logic [Aw:0] side_a_reg;

    logic [15:0] lip_mem [pvpp_pkg::StateDepth];
    logic [15:0] lop_mem [pvpp_pkg::StateDepth];
    logic [15:0] lip_rd_reg, lop_rd_reg;
    logic        fwd_hit_reg;
    logic [15:0] fwd_ip_reg, fwd_op_reg;
    logic [15:0] lip_fwd, lop_fwd;
    logic        wr_en;
    logic [Aw-1:0] wr_addr;
    logic [15:0] wr_ip, wr_op;

    pvpp_pkg::cord_t  mag_b_reg;
    pvpp_pkg::phase_t ph_b_reg, lop_b_reg, sadv_b_reg;
    logic signed [15:0] dev_b_reg;
    logic [Aw:0] side_b_reg;

    logic signed [33:0] sprod;
    pvpp_pkg::cord_t  mag_c_reg;
    pvpp_pkg::phase_t ph_c_reg, lop_c_reg, sadv_c_reg, scl_c_reg;
    logic [Aw:0] side_c_reg;

    // Gain stage 1: magnitude, phase, issue state reads.
    assign mprod = (Cw+18)'(v_out.x) * (Cw+18)'(pvpp_pkg::InvGainQ16) + (Cw+18)'(32768);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_a_reg  <= zero_reg[Lv-1] ? '0 : Cw'(mprod >>> 16);
            ph_a_reg   <= zero_reg[Lv-1] ? '0 : v_out.z[15:0];
            side_a_reg <= side_reg[Lv-1];
            lip_rd_reg <= lip_mem[side_reg[Lv-1][Aw-1:0]];
            lop_rd_reg <= lop_mem[side_reg[Lv-1][Aw-1:0]];
            // The array returns the old word; keep the write landing on this edge aside
            fwd_hit_reg <= wr_en && (wr_addr == side_reg[Lv-1][Aw-1:0]);
            fwd_ip_reg  <= wr_ip;
            fwd_op_reg  <= wr_op;
        end
    end

    // Newest input phase of the bin: stages ahead first, then the caught write, then memory.
    always_comb
    begin
        if (v_reg[StB] && (side_b_reg[Aw-1:0] == side_a_reg[Aw-1:0]))
            lip_fwd = ph_b_reg;
        else if (v_reg[StC] && (side_c_reg[Aw-1:0] == side_a_reg[Aw-1:0]))
            lip_fwd = ph_c_reg;
        else if (fwd_hit_reg)
            lip_fwd = fwd_ip_reg;
        else
            lip_fwd = lip_rd_reg;
    end
    assign lop_fwd = fwd_hit_reg ? fwd_op_reg : lop_rd_reg;

    // Phase stage 2: deviation.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_b_reg  <= mag_a_reg;
            ph_b_reg   <= ph_a_reg;
            // Pick up the output phase written by the bin leaving stage 4 on this edge
            lop_b_reg  <= (wr_en && (wr_addr == side_a_reg[Aw-1:0])) ? wr_op : lop_fwd;
            side_b_reg <= side_a_reg;
            dev_b_reg  <= ph_a_reg - (lip_fwd +
                          pvpp_pkg::bin_advance(14'(ahop_reg), side_a_reg[Aw-1:0]));
            sadv_b_reg <= pvpp_pkg::bin_advance(shop_reg, side_a_reg[Aw-1:0]);
        end
    end

    // Stage 3: scale deviation.
    assign sprod = 34'(dev_b_reg) * $signed({18'd0, ratio_reg}) + 34'sd2048;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_c_reg  <= mag_b_reg;
            ph_c_reg   <= ph_b_reg;
            lop_c_reg  <= (wr_en && (wr_addr == side_b_reg[Aw-1:0])) ? wr_op : lop_b_reg;
            sadv_c_reg <= sadv_b_reg;
            scl_c_reg  <= sprod[27:12];
            side_c_reg <= side_b_reg;
        end
    end

    // Stage 4: output phase, state write, rotation pre-fold.
    pvpp_pkg::phase_t oph;
    assign oph = side_c_reg[Aw] ? ph_c_reg : lop_c_reg + sadv_c_reg + scl_c_reg;
    assign wr_en   = clearing || (adv && v_reg[StC]);
    assign wr_addr = clearing ? clr_reg[Aw-1:0] : side_c_reg[Aw-1:0];
    assign wr_ip   = clearing ? '0 : ph_c_reg;
    assign wr_op   = clearing ? '0 : oph;
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lip_mem[wr_addr] <= wr_ip;
            lop_mem[wr_addr] <= wr_op;
        end
    end

    pvpp_pkg::cord_state_t r0_reg, r_out;
    logic signed [15:0] soph;
    logic               fold;
    assign soph = oph;
    assign fold = (soph > 16'sd16384) || (soph < -16'sd16384);
    logic [Aw-1:0] bin_r_reg [Ns+1];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r0_reg.x <= fold ? -mag_c_reg : mag_c_reg;
            r0_reg.y <= '0;
            r0_reg.z <= fold ? 18'(signed'(16'(soph - 16'sh8000))) : 18'(soph);
            bin_r_reg[0] <= side_c_reg[Aw-1:0];
            for (int i = 1; i <= Ns; i++)
                bin_r_reg[i] <= bin_r_reg[i-1];
        end
    end

    pvpp_cordic u_rot (.clk(clk), .en(adv), .vec(1'b0), .in_s(r0_reg), .out_s(r_out));

    // Gain removal, then rounding/saturation into the output register.
    logic signed [Cw+17:0] xp, yp;
    assign xp = (Cw+18)'(r_out.x) * (Cw+18)'(pvpp_pkg::InvGainQ16) + (Cw+18)'(32768);
    assign yp = (Cw+18)'(r_out.y) * (Cw+18)'(pvpp_pkg::InvGainQ16) + (Cw+18)'(32768);
    pvpp_pkg::cord_t gx_reg, gy_reg;
    logic [Aw-1:0] bin_g_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gx_reg    <= Cw'(xp >>> 16);
            gy_reg    <= Cw'(yp >>> 16);
            bin_g_reg <= bin_r_reg[Ns];
        end
    end

    function automatic logic signed [23:0] sat24(input pvpp_pkg::cord_t v);
        pvpp_pkg::cord_t r;
        begin
            r = (v + Cw'(128)) >>> 8;
            if (r > Cw'(8388607))
                return 24'sd8388607;
            else if (r < -Cw'(8388608))
                return -24'sd8388608;
            else
                return r[23:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v_reg[Depth-1];
    end
    logic signed [23:0] ore_reg, oim_reg;
    logic [Aw-1:0] obin_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ore_reg  <= sat24(gx_reg);
            oim_reg  <= sat24(gy_reg);
            obin_reg <= bin_g_reg;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_real = ore_reg;
    assign out_ch.out_imag = oim_reg;
    assign out_ch.out_bin  = obin_reg;

`ifndef SYNTHESIS
    a_no_take_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ch.ready) else $error("bin taken during clear");
    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v_reg)) else $error("pipeline moved on stall");
    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v_reg[Depth-1])) else $error("invented result");
`endif
endmodule
